[hdl/bpfa_pkg.sv]
// Shared types, codes and bit-mask helpers for the page frame allocator.
`timescale 1ns / 1ps
`default_nettype none

package bpfa_pkg;

  localparam int WORD_BITS  = 32;
  localparam int BIT_W      = 5;
  localparam int ADDR_W     = 32;
  localparam int SIZE_W     = 32;
  localparam int CFG_DATA_W = 33;
  localparam int FUNC_W     = 2;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [BIT_W-1:0]     bitpos_t;
  typedef logic [FUNC_W-1:0]    func_t;

  localparam func_t FUNC_INIT    = 2'd0;
  localparam func_t FUNC_ALLOC   = 2'd1;
  localparam func_t FUNC_FREE    = 2'd2;
  localparam func_t FUNC_RESERVE = 2'd3;

  localparam logic REG_MEMORY_TOP  = 1'b0;
  localparam logic REG_ALLOC_START = 1'b1;

  localparam word_t WORD_ONES = '1;

  // bits at and above position b
  function automatic word_t ge_mask(input bitpos_t b);
    return WORD_ONES << b;
  endfunction

  // bits at and below position b
  function automatic word_t le_mask(input bitpos_t b);
    return WORD_ONES >> (BIT_W'(WORD_BITS - 1) - b);
  endfunction

endpackage

`default_nettype wire

[hdl/bpfa_map_ram.sv]
// Used-bit map storage: one write port, one read port with registered data.
`timescale 1ns / 1ps
`default_nettype none

module bpfa_map_ram #(
  parameter int DEPTH  = 128,
  parameter int ADDR_W = 7
) (
  input  wire                    clk,
  input  wire                    wr_en,
  input  wire  [ADDR_W-1:0]      wr_addr,
  input  bpfa_pkg::word_t        wr_data,
  input  wire                    rd_en,
  input  wire  [ADDR_W-1:0]      rd_addr,
  output bpfa_pkg::word_t        rd_data
);

  bpfa_pkg::word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hdl/bpfa_free_find.sv]
// Lowest-set-bit finder over one map word of free candidates.
`timescale 1ns / 1ps
`default_nettype none

module bpfa_free_find (
  input  bpfa_pkg::word_t   cand,
  output logic              found,
  output bpfa_pkg::bitpos_t idx,
  output bpfa_pkg::word_t   onehot
);

  // isolate the lowest candidate, then encode it
  assign onehot = cand & (~cand + bpfa_pkg::WORD_BITS'(1));
  assign found  = |cand;

  always_comb begin
    idx = '0;
    for (int b = 0; b < bpfa_pkg::BIT_W; b++) begin
      for (int j = 0; j < bpfa_pkg::WORD_BITS; j++) begin
        if (((j >> b) & 1) == 1) begin
          idx[b] = idx[b] | onehot[j];
        end
      end
    end
  end

endmodule

`default_nettype wire

[hdl/bitmap_page_frame_allocator_unit.sv]
// Top level of the bitmap page frame allocator: command sequencer around the map.
//
//  channel  | ports                                        | handshake
//  ---------+----------------------------------------------+--------------------------------
//  command  | start, busy, in_func, in_addr, in_size       | taken when start & !busy
//  result   | out_valid, out_page_addr, out_status         | one-cycle strobe, never stalled
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data    | written when cfg_valid & cfg_ready
//
// Init writes all NUM_WORDS map words once. Allocate reads one word a cycle until a free
// frame shows up. Free and reserve walk the words that they span, the write of word k
// overlapping the read of word k+1; an item with nothing to walk (zero limit, zero reserve
// size, start at or past the limit) returns its result straight from setup.
// Synchronous reset, no clearing pass: frame_limit resets to zero and hides the map
// until the first init rewrites every word. The receiver cannot stall results.

`timescale 1ns / 1ps
`default_nettype none

module bitmap_page_frame_allocator_unit #(
  parameter int NUM_FRAMES = 4096,
  parameter int PAGE_BYTES = 4096
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // command channel
  input  wire                                  start,
  output logic                                 busy,
  input  wire  [bpfa_pkg::FUNC_W-1:0]          in_func,
  input  wire  [bpfa_pkg::ADDR_W-1:0]          in_addr,
  input  wire  [bpfa_pkg::SIZE_W-1:0]          in_size,
  // result channel
  output logic                                 out_valid,
  output logic [bpfa_pkg::ADDR_W-1:0]          out_page_addr,
  output logic                                 out_status,
  // configuration channel
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire                                  cfg_index,
  input  wire  [bpfa_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // ---------------------------------------------------------------------------
  // Geometry. Frame i lives in word i[FXW-1:5], bit i[4:0]; the map is padded to
  // whole words and the padding always sits at or above frame_limit.
  // ---------------------------------------------------------------------------
  localparam int PB_LOG    = $clog2(PAGE_BYTES);
  localparam int NUM_WORDS = (NUM_FRAMES + bpfa_pkg::WORD_BITS - 1) / bpfa_pkg::WORD_BITS;
  localparam int WAW       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int FXW       = WAW + bpfa_pkg::BIT_W;   // frame index
  localparam int FS        = FXW + 1;                 // frame count, up to NUM_FRAMES
  localparam logic [63:0] CAP_BYTES = 64'(NUM_FRAMES) * 64'(PAGE_BYTES);
  localparam logic [WAW-1:0] LAST_WORD = WAW'(NUM_WORDS - 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_INIT  = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_RANGE = 3'd4;

  localparam int BW = bpfa_pkg::BIT_W;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  logic [2:0]                       state_r, state_nxt;
  logic [bpfa_pkg::CFG_DATA_W-1:0]  memory_top_r;
  logic [bpfa_pkg::ADDR_W-1:0]      alloc_start_r;
  logic [FS-1:0]                    limit_r, limit_nxt;
  logic [FS-1:0]                    low_r, low_nxt;
  bpfa_pkg::func_t                  func_r;
  logic [bpfa_pkg::ADDR_W-1:0]      addr_r;
  logic [bpfa_pkg::SIZE_W-1:0]      size_r;
  logic [FXW-1:0]                   first_r, first_nxt;
  logic [FXW-1:0]                   endf_r, endf_nxt;
  logic                             clear_r, clear_nxt;
  logic [WAW-1:0]                   rd_k_r, rd_k_nxt;
  logic [WAW-1:0]                   last_k_r, last_k_nxt;
  logic                             issue_r, issue_nxt;
  logic                             pend_r, pend_nxt;
  logic [WAW-1:0]                   pend_k_r, pend_k_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic [bpfa_pkg::ADDR_W-1:0]      out_addr_r, out_addr_nxt;
  logic                             out_status_r, out_status_nxt;

  logic accept;
  assign accept = start && !busy;

  // ---------------------------------------------------------------------------
  // Map memory and free-bit finder
  // ---------------------------------------------------------------------------
  logic            ram_wr_en;
  logic [WAW-1:0]  ram_wr_addr;
  bpfa_pkg::word_t ram_wr_data;
  logic            ram_rd_en;
  bpfa_pkg::word_t ram_rd_data;

  bpfa_map_ram #(
    .DEPTH  (NUM_WORDS),
    .ADDR_W (WAW)
  ) u_map (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (rd_k_r),
    .rd_data (ram_rd_data)
  );

  bpfa_pkg::word_t   cand;
  logic              cand_found;
  bpfa_pkg::bitpos_t cand_idx;
  bpfa_pkg::word_t   cand_onehot;

  bpfa_free_find u_find (
    .cand   (cand),
    .found  (cand_found),
    .idx    (cand_idx),
    .onehot (cand_onehot)
  );

  // ---------------------------------------------------------------------------
  // Setup arithmetic, all from the captured item and the config registers
  // ---------------------------------------------------------------------------
  logic [32:0]     top_frames;
  logic [32:0]     low_frames;
  logic [FS-1:0]   new_limit;
  logic [FS-1:0]   new_low;
  logic [FS-1:0]   lim_m1;
  logic [31:0]     first_fa;
  logic [32:0]     last_fa;
  logic [32:0]     range_last;
  logic            range_ok;
  logic [FXW-1:0]  first_fx;
  logic [FXW-1:0]  clip_end;

  always_comb begin
    top_frames = memory_top_r >> PB_LOG;
    new_limit  = (64'(memory_top_r) >= CAP_BYTES) ? FS'(NUM_FRAMES) : FS'(top_frames);
    // round the allocation start up to a whole frame, no wraparound
    low_frames = ({1'b0, alloc_start_r} + 33'(PAGE_BYTES - 1)) >> PB_LOG;
    new_low    = (64'(low_frames) > 64'(NUM_FRAMES)) ? FS'(NUM_FRAMES) : FS'(low_frames);
    lim_m1     = limit_r - FS'(1);

    first_fa   = addr_r >> PB_LOG;
    last_fa    = ({1'b0, addr_r} + {1'b0, size_r} - 33'd1) >> PB_LOG;
    range_last = (func_r == bpfa_pkg::FUNC_FREE) ? {1'b0, first_fa} : last_fa;
    range_ok   = (64'(first_fa) < 64'(limit_r)) &&
                 ((func_r == bpfa_pkg::FUNC_FREE) || (size_r != '0));
    first_fx   = FXW'(first_fa);
    // clip the range at the last usable frame
    clip_end   = (64'(range_last) < 64'(limit_r)) ? FXW'(range_last) : FXW'(lim_m1);
  end

  // ---------------------------------------------------------------------------
  // Per-word masks for the word being written
  // ---------------------------------------------------------------------------
  logic [WAW-1:0]  word_k;
  logic [WAW:0]    word_k_ext;
  bpfa_pkg::word_t above_lim;
  bpfa_pkg::word_t below_low;
  bpfa_pkg::word_t range_mask;
  bpfa_pkg::word_t range_word;

  always_comb begin
    word_k     = (state_r == ST_INIT) ? rd_k_r : pend_k_r;
    word_k_ext = {1'b0, word_k};

    if (word_k_ext > limit_r[FS-1:BW]) begin
      above_lim = bpfa_pkg::WORD_ONES;
    end else if (word_k_ext == limit_r[FS-1:BW]) begin
      above_lim = bpfa_pkg::ge_mask(limit_r[BW-1:0]);
    end else begin
      above_lim = '0;
    end

    if (word_k_ext < low_r[FS-1:BW]) begin
      below_low = bpfa_pkg::WORD_ONES;
    end else if (word_k_ext == low_r[FS-1:BW]) begin
      below_low = ~bpfa_pkg::ge_mask(low_r[BW-1:0]);
    end else begin
      below_low = '0;
    end

    range_mask = bpfa_pkg::WORD_ONES;
    if (pend_k_r == first_r[FXW-1:BW]) begin
      range_mask = range_mask & bpfa_pkg::ge_mask(first_r[BW-1:0]);
    end
    if (pend_k_r == endf_r[FXW-1:BW]) begin
      range_mask = range_mask & bpfa_pkg::le_mask(endf_r[BW-1:0]);
    end
    range_word = clear_r ? (ram_rd_data & ~range_mask) : (ram_rd_data | range_mask);

    // free frames below the limit in the returned word
    cand = ~ram_rd_data & ~above_lim;
  end

  // ---------------------------------------------------------------------------
  // Memory port drive
  // ---------------------------------------------------------------------------
  always_comb begin
    ram_rd_en   = issue_r && ((state_r == ST_SCAN) || (state_r == ST_RANGE));
    ram_wr_en   = 1'b0;
    ram_wr_addr = pend_k_r;
    ram_wr_data = range_word;
    case (state_r)
      ST_INIT: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = rd_k_r;
        ram_wr_data = above_lim | below_low;
      end
      ST_SCAN: begin
        ram_wr_en   = pend_r && cand_found;
        ram_wr_data = ram_rd_data | cand_onehot;
      end
      ST_RANGE: begin
        ram_wr_en   = pend_r;
      end
      default: begin
        ram_wr_en   = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    limit_nxt      = limit_r;
    low_nxt        = low_r;
    first_nxt      = first_r;
    endf_nxt       = endf_r;
    clear_nxt      = clear_r;
    rd_k_nxt       = rd_k_r;
    last_k_nxt     = last_k_r;
    issue_nxt      = issue_r;
    pend_nxt       = 1'b0;
    pend_k_nxt     = pend_k_r;
    out_valid_nxt  = 1'b0;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;

    unique case (state_r) inside
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_SETUP;
        end
      end

      ST_SETUP: begin
        unique case (func_r) inside
          bpfa_pkg::FUNC_INIT: begin
            limit_nxt = new_limit;
            low_nxt   = new_low;
            rd_k_nxt  = '0;
            state_nxt = ST_INIT;
          end
          bpfa_pkg::FUNC_ALLOC: begin
            if (limit_r == '0) begin
              // nothing usable: report exhaustion at once
              state_nxt      = ST_IDLE;
              out_valid_nxt  = 1'b1;
              out_addr_nxt   = '0;
              out_status_nxt = 1'b1;
            end else begin
              rd_k_nxt   = '0;
              last_k_nxt = lim_m1[FXW-1:BW];
              issue_nxt  = 1'b1;
              state_nxt  = ST_SCAN;
            end
          end
          bpfa_pkg::FUNC_FREE, bpfa_pkg::FUNC_RESERVE: begin
            clear_nxt = (func_r == bpfa_pkg::FUNC_FREE);
            if (range_ok) begin
              first_nxt  = first_fx;
              endf_nxt   = clip_end;
              rd_k_nxt   = first_fx[FXW-1:BW];
              last_k_nxt = clip_end[FXW-1:BW];
              issue_nxt  = 1'b1;
              state_nxt  = ST_RANGE;
            end else begin
              state_nxt      = ST_IDLE;
              out_valid_nxt  = 1'b1;
              out_addr_nxt   = '0;
              out_status_nxt = 1'b0;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end

      ST_INIT: begin
        if (rd_k_r == LAST_WORD) begin
          state_nxt      = ST_IDLE;
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = '0;
          out_status_nxt = 1'b0;
        end else begin
          rd_k_nxt = rd_k_r + WAW'(1);
        end
      end

      ST_SCAN, ST_RANGE: begin
        // advance the read stream; data returns in the next cycle
        if (issue_r) begin
          pend_nxt   = 1'b1;
          pend_k_nxt = rd_k_r;
          if (rd_k_r == last_k_r) begin
            issue_nxt = 1'b0;
          end else begin
            rd_k_nxt = rd_k_r + WAW'(1);
          end
        end
        if (pend_r) begin
          if ((state_r == ST_SCAN) && cand_found) begin
            state_nxt      = ST_IDLE;
            issue_nxt      = 1'b0;
            out_valid_nxt  = 1'b1;
            out_addr_nxt   = 32'({pend_k_r, cand_idx, {PB_LOG{1'b0}}});
            out_status_nxt = 1'b0;
          end else if (pend_k_r == last_k_r) begin
            // last word handled: a scan that gets here found nothing
            state_nxt      = ST_IDLE;
            issue_nxt      = 1'b0;
            out_valid_nxt  = 1'b1;
            out_addr_nxt   = '0;
            out_status_nxt = (state_r == ST_SCAN);
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      limit_r      <= '0;
      issue_r      <= 1'b0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      out_addr_r   <= '0;
      out_status_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      limit_r      <= limit_nxt;
      issue_r      <= issue_nxt;
      pend_r       <= pend_nxt;
      out_valid_r  <= out_valid_nxt;
      out_addr_r   <= out_addr_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  // working registers; meaningful only once the sequencer loads them
  always_ff @(posedge clk) begin
    low_r    <= low_nxt;
    first_r  <= first_nxt;
    endf_r   <= endf_nxt;
    clear_r  <= clear_nxt;
    rd_k_r   <= rd_k_nxt;
    last_k_r <= last_k_nxt;
    pend_k_r <= pend_k_nxt;
  end

  // hold the captured item for the whole operation
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_func;
      addr_r <= in_addr;
      size_r <= in_size;
    end
  end

  // ---------------------------------------------------------------------------
  // Configuration registers, always writable
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      memory_top_r  <= '0;
      alloc_start_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bpfa_pkg::REG_MEMORY_TOP:  memory_top_r  <= cfg_data;
        bpfa_pkg::REG_ALLOC_START: alloc_start_r <= cfg_data[bpfa_pkg::ADDR_W-1:0];
        default: memory_top_r <= memory_top_r;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Outputs
  // ---------------------------------------------------------------------------
  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_page_addr = out_addr_r;
  assign out_status    = out_status_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("command taken but sequencer did not leave idle");

  a_result_ends_op: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> out_valid)
    else $error("operation ended without a result strobe");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |-> !ram_wr_en)
    else $error("map written while idle");

  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != rd_k_r))
    else $error("map word read and written in the same cycle");

endmodule

`default_nettype wire
